// ===== hdl/jst_pkg.sv =====
// Package for the JSON-style tokenizer: item types, token and error codes,
// character constants and the small decode functions. No dependencies.
package jst_pkg;

    // Width of the byte position and token start counters.
    localparam int POS_BITS = 20;
    // Width of the offset, length and line fields of a token.
    localparam int OUT_W = 20;

    // Result queue: one item can raise up to three tokens.
    localparam int MAX_TOK = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int TCNT_W = $clog2(MAX_TOK + 1);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [OUT_W-1:0] LINE_MAX = '1;

    typedef enum logic [2:0] {
        LM_IDLE   = 3'd0,
        LM_STRING = 3'd1,
        LM_NUM    = 3'd2,
        LM_NUMDOT = 3'd3,
        LM_FRAC   = 3'd4,
        LM_WORD   = 3'd5,
        LM_ERROR  = 3'd6
    } lex_mode_t;

    typedef enum logic [3:0] {
        TK_LBRACE   = 4'd0,
        TK_RBRACE   = 4'd1,
        TK_COMMA    = 4'd2,
        TK_LBRACKET = 4'd3,
        TK_RBRACKET = 4'd4,
        TK_COLON    = 4'd5,
        TK_DOT      = 4'd6,
        TK_STRING   = 4'd7,
        TK_NUMBER   = 4'd8,
        TK_BOOLEAN  = 4'd9,
        TK_NULL     = 4'd10,
        TK_EOF      = 4'd11,
        TK_ERROR    = 4'd12
    } tok_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_CHAR = 2'd1,
        ERR_UNTERM   = 2'd2,
        ERR_NO_DIGIT = 2'd3
    } err_code_t;

    // Input item kinds.
    localparam logic IN_BYTE = 1'b0;
    localparam logic IN_END  = 1'b1;

    // Character codes.
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LC_A     = 8'h61;
    localparam logic [7:0] CH_LC_Z     = 8'h7A;
    localparam logic [7:0] CH_UC_A     = 8'h41;
    localparam logic [7:0] CH_UC_Z     = 8'h5A;

    // Keyword candidates, one bit each in the match mask.
    localparam int W_TRUE  = 0;
    localparam int W_FALSE = 1;
    localparam int W_NULL  = 2;
    localparam logic [2:0] LEN_TRUE  = 3'd4;
    localparam logic [2:0] LEN_FALSE = 3'd5;
    localparam logic [2:0] LEN_NULL  = 3'd4;
    localparam logic [2:0] WORD_ALL  = 3'b111;

    typedef struct packed {
        tok_kind_t          kind;
        err_code_t          err;
        logic               bval;
        logic [OUT_W-1:0]   offset;
        logic [OUT_W-1:0]   length;
        logic [OUT_W-1:0]   line;
        logic               last;
    } token_t;

    typedef struct packed {
        logic      hit;
        tok_kind_t kind;
    } punct_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
    endfunction

    function automatic punct_t punct_of(input logic [7:0] c);
        punct_t p;
        p.hit = 1'b1;
        case (c)
            CH_LBRACE:   p.kind = TK_LBRACE;
            CH_RBRACE:   p.kind = TK_RBRACE;
            CH_COMMA:    p.kind = TK_COMMA;
            CH_LBRACKET: p.kind = TK_LBRACKET;
            CH_RBRACKET: p.kind = TK_RBRACKET;
            CH_COLON:    p.kind = TK_COLON;
            CH_DOT:      p.kind = TK_DOT;
            default:
            begin
                p.hit  = 1'b0;
                p.kind = TK_LBRACE;
            end
        endcase
        return p;
    endfunction

    // Expected letter of a keyword at a given index. Positions past the end of
    // the word give zero, which no letter equals.
    function automatic logic [7:0] word_char(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] ch;
        case ({k, idx})
            {2'd0, 3'd0}: ch = 8'h74;
            {2'd0, 3'd1}: ch = 8'h72;
            {2'd0, 3'd2}: ch = 8'h75;
            {2'd0, 3'd3}: ch = 8'h65;
            {2'd1, 3'd0}: ch = 8'h66;
            {2'd1, 3'd1}: ch = 8'h61;
            {2'd1, 3'd2}: ch = 8'h6C;
            {2'd1, 3'd3}: ch = 8'h73;
            {2'd1, 3'd4}: ch = 8'h65;
            {2'd2, 3'd0}: ch = 8'h6E;
            {2'd2, 3'd1}: ch = 8'h75;
            {2'd2, 3'd2}: ch = 8'h6C;
            {2'd2, 3'd3}: ch = 8'h6C;
            default:      ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] word_next(input logic [2:0] match,
                                             input logic [2:0] letters,
                                             input logic [7:0] c);
        logic [2:0] m;
        m = match;
        for (int k = 0; k < 3; k++)
        begin
            if (word_char(2'(k), letters) != c)
                m[k] = 1'b0;
        end
        return m;
    endfunction

    function automatic token_t mk_token(input tok_kind_t kind, input err_code_t err,
                                        input logic bval, input logic [OUT_W-1:0] off,
                                        input logic [OUT_W-1:0] len,
                                        input logic [OUT_W-1:0] line);
        token_t t;
        t.kind   = kind;
        t.err    = err;
        t.bval   = bval;
        t.offset = off;
        t.length = len;
        t.line   = line;
        t.last   = 1'b0;
        return t;
    endfunction

endpackage

// ===== hdl/json_style_tokenizer_core.sv =====
// Top level of the JSON-style tokenizer: input register, lexer state machine
// and a small result queue. Depends on jst_pkg.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata = char_code, s_tuser = kind
// m_*       out  m_tvalid/m_tready  m_tuser = token_kind, m_tdata = token fields,
//                                   m_tlast = last token raised by an item
//
// An item is taken into the input register, lexed from there once the queue
// has room, and its tokens (zero to three) are written into an eight-entry
// queue in one go. The queue drives the output one token per cycle while
// m_tready is high, so a new item is accepted every cycle while each item
// raises at most one token on average; the queue write port needs room for
// three tokens, so lexing stalls while the queue holds more than five.
// Reset (rst_n low, asynchronous) empties the queue and input register and
// puts the lexer into idle with position zero and line one.
module json_style_tokenizer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [1:0] error_code, [2] bool_value,
                                   // [22:3] token_offset, [42:23] token_length,
                                   // [62:43] token_line, [63] zero
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast
);

    localparam int PB = jst_pkg::POS_BITS;
    localparam int OW = jst_pkg::OUT_W;

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic       in_kind_reg;
    logic [7:0] in_char_reg;

    // Lexer state.
    jst_pkg::lex_mode_t mode_reg, mode_next;
    logic [PB-1:0] pos_reg, pos_next;
    logic [PB-1:0] start_reg, start_next;
    logic [OW-1:0] line_reg, line_next;
    logic          digit_reg, digit_next;
    logic [2:0]    match_reg, match_next;
    logic [2:0]    letters_reg, letters_next;

    // Result queue.
    jst_pkg::token_t                   fifo_reg [jst_pkg::FIFO_DEPTH];
    logic [jst_pkg::PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [jst_pkg::PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [jst_pkg::CNT_W-1:0]         count_reg, count_next;

    logic room, process, s_accept, pop;

    // Shared decode of the current byte.
    logic            is_end, dig, alp, quote, dot, ws, nl, sign;
    jst_pkg::punct_t pun;
    logic            go_idle, num_err, idle_bad;
    logic [PB-1:0]   span, span_m1, pos_m1;
    logic            hit_true, hit_false, hit_null, word_hit;

    // Tokens raised by the item in the input register.
    jst_pkg::token_t          tok [jst_pkg::MAX_TOK];
    logic [jst_pkg::TCNT_W-1:0] tok_cnt;

    assign room     = count_reg <= jst_pkg::CNT_W'(jst_pkg::FIFO_DEPTH - jst_pkg::MAX_TOK);
    assign process  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;
    assign s_accept = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (process)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_kind_reg <= s_tuser;
            in_char_reg <= s_tdata;
        end
    end

    // Character classes and the decisions shared by both state blocks.
    always_comb
    begin
        is_end = (in_kind_reg == jst_pkg::IN_END);
        dig    = jst_pkg::is_digit(in_char_reg);
        alp    = jst_pkg::is_alpha(in_char_reg);
        quote  = (in_char_reg == jst_pkg::CH_QUOTE);
        dot    = (in_char_reg == jst_pkg::CH_DOT);
        ws     = (in_char_reg == jst_pkg::CH_SPACE) || (in_char_reg == jst_pkg::CH_CR)
              || (in_char_reg == jst_pkg::CH_TAB);
        nl     = (in_char_reg == jst_pkg::CH_NL);
        sign   = (in_char_reg == jst_pkg::CH_MINUS) || (in_char_reg == jst_pkg::CH_PLUS);
        pun    = jst_pkg::punct_of(in_char_reg);

        // A byte that starts nothing known from idle is an invalid character.
        idle_bad = !(pun.hit || ws || nl || quote || sign || dig || alp);

        // A byte met in idle, or one that ends the pending number or word and is then lexed from idle.
        go_idle = (mode_reg == jst_pkg::LM_IDLE)
               || ((mode_reg == jst_pkg::LM_NUM) && !dig && !dot && digit_reg)
               || ((mode_reg == jst_pkg::LM_NUMDOT) && !dig && digit_reg)
               || ((mode_reg == jst_pkg::LM_FRAC) && !dig && digit_reg)
               || ((mode_reg == jst_pkg::LM_WORD) && !alp);

        // A number that ends without any digit, i.e. a sign with no digit, alone or followed by a dot.
        num_err = ((mode_reg == jst_pkg::LM_NUM) && !dig && !dot && !digit_reg)
               || ((mode_reg == jst_pkg::LM_NUMDOT) && !dig && !digit_reg)
               || ((mode_reg == jst_pkg::LM_FRAC) && !dig && !digit_reg);

        span    = (pos_reg > start_reg) ? (pos_reg - start_reg) : '0;
        span_m1 = (span != '0) ? (span - PB'(1)) : '0;
        pos_m1  = (pos_reg != '0) ? (pos_reg - PB'(1)) : '0;

        hit_true  = match_reg[jst_pkg::W_TRUE] && (letters_reg == jst_pkg::LEN_TRUE);
        hit_false = match_reg[jst_pkg::W_FALSE] && (letters_reg == jst_pkg::LEN_FALSE);
        hit_null  = match_reg[jst_pkg::W_NULL] && (letters_reg == jst_pkg::LEN_NULL);
        word_hit  = hit_true || hit_false || hit_null;
    end

    // Next state of the lexer.
    always_comb
    begin
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        line_next    = line_reg;
        digit_next   = digit_reg;
        match_next   = match_reg;
        letters_next = letters_reg;

        if (process)
        begin
            if (is_end)
            begin
                // End of input always brings the lexer back to its reset state.
                mode_next    = jst_pkg::LM_IDLE;
                pos_next     = '0;
                start_next   = '0;
                line_next    = OW'(1);
                digit_next   = 1'b0;
                match_next   = jst_pkg::WORD_ALL;
                letters_next = '0;
            end
            else
            begin
                if (pos_reg != jst_pkg::POS_MAX)
                    pos_next = pos_reg + PB'(1);

                case (mode_reg)
                    jst_pkg::LM_STRING:
                    begin
                        if (quote)
                            mode_next = jst_pkg::LM_IDLE;
                    end
                    jst_pkg::LM_NUM:
                    begin
                        if (dig)
                            digit_next = 1'b1;
                        else if (dot)
                            mode_next = jst_pkg::LM_NUMDOT;
                    end
                    jst_pkg::LM_NUMDOT:
                    begin
                        if (dig)
                        begin
                            mode_next  = jst_pkg::LM_FRAC;
                            digit_next = 1'b1;
                        end
                    end
                    jst_pkg::LM_WORD:
                    begin
                        if (alp)
                        begin
                            match_next = jst_pkg::word_next(match_reg, letters_reg,
                                                            in_char_reg);
                            if (letters_reg != 3'd7)
                                letters_next = letters_reg + 3'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (num_err)
                    mode_next = jst_pkg::LM_ERROR;

                if (go_idle)
                begin
                    mode_next  = jst_pkg::LM_IDLE;
                    start_next = pos_reg;
                    if (nl)
                    begin
                        if (line_reg != jst_pkg::LINE_MAX)
                            line_next = line_reg + OW'(1);
                    end
                    else if (quote)
                        mode_next = jst_pkg::LM_STRING;
                    else if (sign)
                    begin
                        mode_next  = jst_pkg::LM_NUM;
                        digit_next = 1'b0;
                    end
                    else if (dig)
                    begin
                        mode_next  = jst_pkg::LM_NUM;
                        digit_next = 1'b1;
                    end
                    else if (alp)
                    begin
                        mode_next    = jst_pkg::LM_WORD;
                        match_next   = jst_pkg::word_next(jst_pkg::WORD_ALL, 3'd0,
                                                          in_char_reg);
                        letters_next = 3'd1;
                    end
                    else if (idle_bad)
                        mode_next = jst_pkg::LM_ERROR;
                end
            end
        end
    end

    // Tokens raised by the item, appended in order.
    always_comb
    begin
        logic [jst_pkg::TCNT_W-1:0] n;
        jst_pkg::token_t            t_num, t_numdot, t_dot, t_eof, t_word, t_nodig;

        n = '0;
        for (int i = 0; i < jst_pkg::MAX_TOK; i++)
            tok[i] = jst_pkg::mk_token(jst_pkg::TK_EOF, jst_pkg::ERR_NONE, 1'b0,
                                       '0, '0, line_reg);

        t_num    = jst_pkg::mk_token(jst_pkg::TK_NUMBER, jst_pkg::ERR_NONE, 1'b0,
                                     OW'(start_reg), OW'(span), line_reg);
        t_numdot = jst_pkg::mk_token(jst_pkg::TK_NUMBER, jst_pkg::ERR_NONE, 1'b0,
                                     OW'(start_reg), OW'(span_m1), line_reg);
        t_dot    = jst_pkg::mk_token(jst_pkg::TK_DOT, jst_pkg::ERR_NONE, 1'b0,
                                     OW'(pos_m1), OW'(1), line_reg);
        t_eof    = jst_pkg::mk_token(jst_pkg::TK_EOF, jst_pkg::ERR_NONE, 1'b0,
                                     OW'(pos_reg), '0, line_reg);
        t_nodig  = jst_pkg::mk_token(jst_pkg::TK_ERROR, jst_pkg::ERR_NO_DIGIT, 1'b0,
                                     OW'(start_reg), '0, line_reg);
        t_word   = jst_pkg::mk_token(hit_null ? jst_pkg::TK_NULL : jst_pkg::TK_BOOLEAN,
                                     jst_pkg::ERR_NONE, hit_true, OW'(start_reg),
                                     OW'(letters_reg), line_reg);

        if (is_end)
        begin
            case (mode_reg)
                jst_pkg::LM_IDLE:
                begin
                    tok[n] = t_eof;
                    n = n + 1'b1;
                end
                jst_pkg::LM_STRING:
                begin
                    tok[n] = jst_pkg::mk_token(jst_pkg::TK_ERROR, jst_pkg::ERR_UNTERM, 1'b0,
                                               OW'(start_reg), '0, line_reg);
                    n = n + 1'b1;
                end
                jst_pkg::LM_NUM, jst_pkg::LM_FRAC:
                begin
                    tok[n] = digit_reg ? t_num : t_nodig;
                    n = n + 1'b1;
                    if (digit_reg)
                    begin
                        tok[n] = t_eof;
                        n = n + 1'b1;
                    end
                end
                jst_pkg::LM_NUMDOT:
                begin
                    tok[n] = digit_reg ? t_numdot : t_nodig;
                    n = n + 1'b1;
                    if (digit_reg)
                    begin
                        tok[n] = t_dot;
                        n = n + 1'b1;
                        tok[n] = t_eof;
                        n = n + 1'b1;
                    end
                end
                jst_pkg::LM_WORD:
                begin
                    if (word_hit)
                    begin
                        tok[n] = t_word;
                        n = n + 1'b1;
                    end
                    tok[n] = t_eof;
                    n = n + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            if ((mode_reg == jst_pkg::LM_STRING) && quote)
            begin
                tok[n] = jst_pkg::mk_token(jst_pkg::TK_STRING, jst_pkg::ERR_NONE, 1'b0,
                                           OW'({1'b0, start_reg} + (PB + 1)'(1)),
                                           OW'(span_m1), line_reg);
                n = n + 1'b1;
            end

            if (num_err)
            begin
                tok[n] = t_nodig;
                n = n + 1'b1;
            end

            if (go_idle)
            begin
                // Close whatever was pending before lexing the byte from idle.
                case (mode_reg)
                    jst_pkg::LM_NUM, jst_pkg::LM_FRAC:
                    begin
                        tok[n] = t_num;
                        n = n + 1'b1;
                    end
                    jst_pkg::LM_NUMDOT:
                    begin
                        tok[n] = t_numdot;
                        n = n + 1'b1;
                        tok[n] = t_dot;
                        n = n + 1'b1;
                    end
                    jst_pkg::LM_WORD:
                    begin
                        if (word_hit)
                        begin
                            tok[n] = t_word;
                            n = n + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (pun.hit)
                begin
                    tok[n] = jst_pkg::mk_token(pun.kind, jst_pkg::ERR_NONE, 1'b0,
                                               OW'(pos_reg), OW'(1), line_reg);
                    n = n + 1'b1;
                end
                else if (idle_bad)
                begin
                    tok[n] = jst_pkg::mk_token(jst_pkg::TK_ERROR, jst_pkg::ERR_BAD_CHAR,
                                               1'b0, OW'(pos_reg), OW'(1), line_reg);
                    n = n + 1'b1;
                end
            end
        end

        if (n != '0)
            tok[n - 1'b1].last = 1'b1;
        tok_cnt = n;
    end

    // Queue pointers and fill count.
    always_comb
    begin
        logic [jst_pkg::TCNT_W-1:0] wr_cnt;
        wr_cnt      = process ? tok_cnt : '0;
        wr_ptr_next = wr_ptr_reg + jst_pkg::PTR_W'(wr_cnt);
        rd_ptr_next = rd_ptr_reg + jst_pkg::PTR_W'(pop);
        count_next  = count_reg + jst_pkg::CNT_W'(wr_cnt) - jst_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < jst_pkg::MAX_TOK; i++)
        begin
            if (process && (jst_pkg::TCNT_W'(i) < tok_cnt))
                fifo_reg[wr_ptr_reg + jst_pkg::PTR_W'(i)] <= tok[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= jst_pkg::LM_IDLE;
            pos_reg      <= '0;
            start_reg    <= '0;
            line_reg     <= OW'(1);
            digit_reg    <= 1'b0;
            match_reg    <= jst_pkg::WORD_ALL;
            letters_reg  <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            line_reg     <= line_next;
            digit_reg    <= digit_next;
            match_reg    <= match_next;
            letters_reg  <= letters_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

    // The queue head drives the output directly.
    assign m_tvalid = (count_reg != '0);
    assign m_tuser  = fifo_reg[rd_ptr_reg].kind;
    assign m_tlast  = fifo_reg[rd_ptr_reg].last;
    assign m_tdata  = {1'b0, fifo_reg[rd_ptr_reg].line, fifo_reg[rd_ptr_reg].length,
                       fifo_reg[rd_ptr_reg].offset, fifo_reg[rd_ptr_reg].bval,
                       fifo_reg[rd_ptr_reg].err};

endmodule

// ===== hdl/jst_checker.sv =====
// Port-level checks for the JSON-style tokenizer and the bind that attaches
// them to json_style_tokenizer_core. Depends on jst_pkg.
module jst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // A waiting token holds still until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("output token changed while stalled");

    // The end-of-input token is always the final token of its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == jst_pkg::TK_EOF) |-> m_tlast)
        else $error("eof token not marked last");

    // Error tokens and only error tokens carry an error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == jst_pkg::TK_ERROR) == (m_tdata[1:0] != 2'd0)))
        else $error("error code does not match token kind");

    // The boolean value is set only on boolean tokens.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != jst_pkg::TK_BOOLEAN) |-> !m_tdata[2])
        else $error("bool value set on a non-boolean token");

    // Line numbers start at one and never wrap to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[62:43] != 20'd0))
        else $error("token line is zero");

endmodule

bind json_style_tokenizer_core jst_checker u_jst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
